// ===== rtl/srs_pkg.sv =====
// Package for signed_radix_to_symbols: sizes, symbol codes, controller types.
// No dependencies; imported by all modules of the block.
package srs_pkg;
   localparam int MaxSymbols = 128;
   localparam int ValueWidth = 32;
   localparam int IdxWidth   = 7;
   localparam int CntWidth   = 6;
   localparam int BitCntW    = 6;

   localparam logic [7:0] SymMinus = 8'd45;
   localparam logic [7:0] SymPlus  = 8'd43;
   localparam logic [7:0] SymSpace = 8'd32;
   localparam logic [7:0] SymDel   = 8'd127;

   localparam logic OpWrite   = 1'b0;
   localparam logic OpConvert = 1'b1;

   typedef enum logic [3:0] {
      ST_IDLE, ST_CHK_LEN, ST_CHK_RD, ST_CHK_A, ST_CHK_B, ST_ERR,
      ST_LOAD, ST_DIV, ST_DIGIT, ST_SIGN, ST_OUT_RD, ST_OUT
   } state_type;

   typedef struct packed {
      logic load_a;     // latch outer symbol, set b = a+1
      logic step_b;
      logic step_a;
      logic rd_b;       // alphabet read address = b
      logic rd_out;     // alphabet read address = digit buffer top
      logic load_mag;
      logic div_start;
      logic div_step;
      logic push_digit;
      logic pop_digit;
      logic clr_a;
   } cmd_type;

   typedef struct packed {
      logic len_ok;
      logic sym_bad;
      logic dup;
      logic a_done;
      logic b_done;
      logic div_done;
      logic mag_zero;
      logic neg;
      logic cnt_one;
   } sts_type;
endpackage

// ===== rtl/srs_datapath.sv =====
// Datapath for signed_radix_to_symbols: alphabet memory, checker indexes,
// restoring divider, digit buffer. Depends on srs_pkg.
module srs_datapath import srs_pkg::*; (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  wr_en,
   input  logic [IdxWidth-1:0]   wr_idx,
   input  logic [7:0]            wr_val,
   input  logic [ValueWidth-1:0] number,
   input  logic [7:0]            base_len,
   input  cmd_type               cmd,
   output sts_type               sts,
   output logic [7:0]            rd_sym
);
   logic [7:0] mem [MaxSymbols];
   logic [7:0] rd_ff;
   logic [7:0] a_ff, a_in, b_ff, b_in;
   logic [7:0] sa_ff;
   logic [ValueWidth-1:0] q_ff, q_in;
   logic [7:0] r_ff, r_in;
   logic [BitCntW-1:0] bc_ff, bc_in;
   logic [IdxWidth-1:0] dbuf [ValueWidth];
   logic [CntWidth-1:0] cnt_ff, cnt_in;
   logic neg_ff;
   logic [IdxWidth-1:0] raddr;
   logic [8:0] trial;

   always_comb begin
      if (cmd.rd_out) raddr = dbuf[cnt_ff[4:0] - 5'd1];
      else if (cmd.rd_b) raddr = b_ff[IdxWidth-1:0];
      else raddr = a_ff[IdxWidth-1:0];
   end

   always_ff @(posedge clock) begin
      if (wr_en) mem[wr_idx] <= wr_val;
      rd_ff <= mem[raddr];
      if (cmd.load_a) sa_ff <= rd_ff;
      if (cmd.load_mag) neg_ff <= number[ValueWidth-1];
      if (cmd.push_digit) dbuf[cnt_ff[4:0]] <= r_ff[IdxWidth-1:0];
   end
   assign rd_sym = rd_ff;

   assign trial = {r_ff, q_ff[ValueWidth-1]} - {1'b0, base_len};

   always_comb begin
      a_in = a_ff; b_in = b_ff; q_in = q_ff; r_in = r_ff; bc_in = bc_ff;
      cnt_in = cnt_ff;
      if (cmd.clr_a) a_in = '0;
      if (cmd.load_a) b_in = a_ff + 8'd1;
      if (cmd.step_b) b_in = b_ff + 8'd1;
      if (cmd.step_a) a_in = a_ff + 8'd1;
      if (cmd.load_mag) begin
         q_in = number[ValueWidth-1] ? (~number + 1'b1) : number;
         cnt_in = '0;
      end
      if (cmd.div_start) begin
         r_in = '0; bc_in = '0;
      end
      if (cmd.div_step) begin
         bc_in = bc_ff + 1'b1;
         if (!trial[8]) begin
            r_in = trial[7:0]; q_in = {q_ff[ValueWidth-2:0], 1'b1};
         end else begin
            r_in = {r_ff[6:0], q_ff[ValueWidth-1]}; q_in = {q_ff[ValueWidth-2:0], 1'b0};
         end
      end
      if (cmd.push_digit) cnt_in = cnt_ff + 1'b1;
      if (cmd.pop_digit) cnt_in = cnt_ff - 1'b1;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         a_ff <= '0; b_ff <= '0; q_ff <= '0; r_ff <= '0; bc_ff <= '0; cnt_ff <= '0;
      end else begin
         a_ff <= a_in; b_ff <= b_in; q_ff <= q_in; r_ff <= r_in; bc_ff <= bc_in;
         cnt_ff <= cnt_in;
      end
   end

   assign sts.len_ok = base_len >= 8'd2 && base_len <= 8'(MaxSymbols);
   assign sts.sym_bad = rd_ff <= SymSpace || rd_ff >= SymDel || rd_ff == SymMinus
                        || rd_ff == SymPlus;
   assign sts.dup = rd_ff == sa_ff;
   assign sts.a_done = (a_ff + 8'd1) >= base_len;
   assign sts.b_done = (b_ff + 8'd1) >= base_len;
   assign sts.div_done = bc_ff == BitCntW'(ValueWidth - 1);
   assign sts.mag_zero = q_ff == '0;
   assign sts.neg = neg_ff;
   assign sts.cnt_one = cnt_ff == CntWidth'(1);
endmodule

// ===== rtl/srs_ctrl.sv =====
// Controller state machine for signed_radix_to_symbols.
// Depends on srs_pkg; drives srs_datapath by command struct.
module srs_ctrl import srs_pkg::*; (
   input  logic    clock,
   input  logic    reset,
   input  logic    go,
   input  sts_type sts,
   output cmd_type cmd,
   output logic    busy,
   output logic    out_valid,
   output logic    out_err,
   output logic    out_minus,
   output logic    out_last
);
   state_type state_ff, state_in;

   always_ff @(posedge clock) begin
      if (reset) state_ff <= ST_IDLE;
      else state_ff <= state_in;
   end

   always_comb begin
      state_in = state_ff;
      cmd = '0;
      out_valid = 1'b0; out_err = 1'b0; out_minus = 1'b0; out_last = 1'b0;
      busy = state_ff != ST_IDLE;
      case (state_ff)
         ST_IDLE: begin
            cmd.clr_a = 1'b1;
            if (go) state_in = ST_CHK_LEN;
         end
         // read alphabet[a]; data arrives next cycle
         ST_CHK_LEN: state_in = sts.len_ok ? ST_CHK_RD : ST_ERR;
         ST_CHK_RD: begin
            if (sts.sym_bad) state_in = ST_ERR;
            else begin
               cmd.load_a = 1'b1;
               state_in = sts.a_done ? ST_LOAD : ST_CHK_A;
            end
         end
         ST_CHK_A: begin
            cmd.rd_b = 1'b1;
            state_in = ST_CHK_B;
         end
         ST_CHK_B: begin
            if (sts.dup) state_in = ST_ERR;
            else if (sts.b_done) begin
               cmd.step_a = 1'b1;
               state_in = ST_CHK_LEN;
            end else begin
               cmd.step_b = 1'b1;
               state_in = ST_CHK_A;
            end
         end
         ST_ERR: begin
            out_valid = 1'b1; out_err = 1'b1; out_last = 1'b1;
            state_in = ST_IDLE;
         end
         ST_LOAD: begin
            cmd.load_mag = 1'b1; cmd.div_start = 1'b1;
            state_in = ST_DIV;
         end
         ST_DIV: begin
            cmd.div_step = 1'b1;
            if (sts.div_done) state_in = ST_DIGIT;
         end
         ST_DIGIT: begin
            cmd.push_digit = 1'b1; cmd.div_start = 1'b1;
            state_in = sts.mag_zero ? ST_SIGN : ST_DIV;
         end
         ST_SIGN: begin
            cmd.rd_out = 1'b1;
            if (sts.neg) begin
               out_valid = 1'b1; out_minus = 1'b1;
            end
            state_in = ST_OUT_RD;
         end
         ST_OUT_RD: begin
            cmd.rd_out = 1'b1;
            state_in = ST_OUT;
         end
         ST_OUT: begin
            out_valid = 1'b1;
            out_last = sts.cnt_one;
            cmd.pop_digit = 1'b1;
            state_in = sts.cnt_one ? ST_IDLE : ST_OUT_RD;
         end
         default: state_in = ST_IDLE;
      endcase
   end

`ifndef SYNTH
   a_idle_quiet: assert property (@(posedge clock) disable iff (reset)
      state_ff == ST_IDLE |-> !out_valid) else $error("strobe while idle");
   a_err_last: assert property (@(posedge clock) disable iff (reset)
      out_err |-> out_last && out_valid) else $error("error without last");
   a_err_idle: assert property (@(posedge clock) disable iff (reset)
      out_err |=> state_ff == ST_IDLE) else $error("error not final");
`endif
endmodule

// ===== rtl/signed_radix_to_symbols.sv =====
// Top level of signed_radix_to_symbols: csr register, controller, datapath.
// Depends on srs_pkg, srs_ctrl, srs_datapath.
//
// Requests are taken when start is high and busy is low. A write request
// (opcode 0) stores one alphabet symbol. A convert request first walks the
// alphabet, checking each symbol and each symbol pair, then divides by the
// radix with a 32-step restoring divider, one division per digit, then
// emits the sign (if negative) and the digits through the alphabet read
// port. Results appear for one cycle on rsp_valid and cannot be stalled.
// Alphabet entries in use must be written before a convert.
module signed_radix_to_symbols import srs_pkg::*; (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  start,
   output logic                  busy,
   input  logic                  req_opcode,
   input  logic [IdxWidth-1:0]   req_symbol_index,
   input  logic [7:0]            req_symbol_value,
   input  logic signed [ValueWidth-1:0] req_number,
   input  logic                  csr_we,
   input  logic [7:0]            csr_wdata,
   output logic                  rsp_valid,
   output logic [7:0]            rsp_symbol,
   output logic                  rsp_error,
   output logic                  rsp_last
);
   logic [7:0] base_ff;
   logic [ValueWidth-1:0] num_ff;
   logic accept, wr_en, go;
   cmd_type cmd;
   sts_type sts;
   logic [7:0] rd_sym;
   logic o_err, o_minus;

   // hold the radix
   always_ff @(posedge clock) begin
      if (reset) base_ff <= '0;
      else if (csr_we) base_ff <= csr_wdata;
   end

   assign accept = start && !busy;
   assign wr_en  = accept && req_opcode == OpWrite;
   assign go     = accept && req_opcode == OpConvert;

   // hold the number for the convert
   always_ff @(posedge clock) begin
      if (go) num_ff <= req_number;
   end

   srs_ctrl u_ctrl (
      .clock(clock), .reset(reset), .go(go), .sts(sts), .cmd(cmd), .busy(busy),
      .out_valid(rsp_valid), .out_err(o_err), .out_minus(o_minus), .out_last(rsp_last)
   );

   srs_datapath u_dp (
      .clock(clock), .reset(reset), .wr_en(wr_en), .wr_idx(req_symbol_index),
      .wr_val(req_symbol_value), .number(num_ff), .base_len(base_ff),
      .cmd(cmd), .sts(sts), .rd_sym(rd_sym)
   );

   assign rsp_error  = o_err;
   assign rsp_symbol = o_err ? 8'd0 : (o_minus ? SymMinus : rd_sym);
endmodule

// ===== sim/signed_radix_to_symbols_tb.sv =====
`timescale 1ns / 100ps
// Self-checking testbench for signed_radix_to_symbols: alphabet writes and
// convert requests checked against an in-bench predictor. Depends on srs_pkg and signed_radix_to_symbols.
module signed_radix_to_symbols_tb;
   import srs_pkg::*;

   localparam int StallLimit = 200000;

   typedef struct {
      logic                         op;
      logic [IdxWidth-1:0]          idx;
      logic [7:0]                   val;
      logic signed [ValueWidth-1:0] num;
   } request_type;

   typedef struct {
      logic [7:0] sym;
      logic       err;
      logic       last;
   } symbol_out_type;

   logic                         clock = 1'b0;
   logic                         reset = 1'b1;
   logic                         start = 1'b0;
   logic                         busy;
   logic                         req_opcode = OpWrite;
   logic [IdxWidth-1:0]          req_symbol_index = '0;
   logic [7:0]                   req_symbol_value = '0;
   logic signed [ValueWidth-1:0] req_number = '0;
   logic                         csr_we = 1'b0;
   logic [7:0]                   csr_wdata = '0;
   logic                         rsp_valid;
   logic [7:0]                   rsp_symbol;
   logic                         rsp_error;
   logic                         rsp_last;

   request_type    pending_reqs[$];
   symbol_out_type expected_syms[$];

   // predictor copy of the alphabet table and the base length register
   logic [7:0] pred_alphabet[MaxSymbols];
   logic [7:0] pred_base;

   logic [7:0] printable[$];   // every byte that may serve as a digit symbol
   int         mismatches = 0;
   int         accepted = 0;
   int         stall_cycles = 0;
   bit         req_taken = 0;
   bit         hold_sender = 0;

   signed_radix_to_symbols DUT (
      .clock(clock), .reset(reset), .start(start), .busy(busy),
      .req_opcode(req_opcode), .req_symbol_index(req_symbol_index),
      .req_symbol_value(req_symbol_value), .req_number(req_number),
      .csr_we(csr_we), .csr_wdata(csr_wdata), .rsp_valid(rsp_valid),
      .rsp_symbol(rsp_symbol), .rsp_error(rsp_error), .rsp_last(rsp_last)
   );

   always begin
      #2 clock = 1'b1;
      #2 clock = 1'b0;
   end

   task automatic report_mismatch(input string what, input int got, input int want);
      $display("%0t mismatch on %s: got %0h, expected %0h", $realtime, what, got, want);
      mismatches++;
   endtask

   function automatic bit alphabet_ok();
      int n;
      n = pred_base;
      if (n < 2 || n > MaxSymbols) return 0;
      for (int a = 0; a < n; a++) begin
         if (pred_alphabet[a] <= SymSpace || pred_alphabet[a] >= SymDel ||
             pred_alphabet[a] == SymMinus || pred_alphabet[a] == SymPlus) return 0;
         for (int b = a + 1; b < n; b++)
            if (pred_alphabet[b] == pred_alphabet[a]) return 0;
      end
      return 1;
   endfunction

   // Work out the symbols one accepted request produces.
   function automatic void predict_symbols(input request_type r);
      longint         mag;
      int             ndig;
      int             digits[ValueWidth];
      symbol_out_type o;
      if (r.op == OpWrite) begin
         pred_alphabet[r.idx] = r.val;
         return;
      end
      if (!alphabet_ok()) begin
         o = '{8'd0, 1'b1, 1'b1};
         expected_syms.push_back(o);
         return;
      end
      // widen so the most negative value keeps its magnitude
      mag = longint'(r.num);
      if (mag < 0) begin
         mag = -mag;
         o = '{SymMinus, 1'b0, 1'b0};
         expected_syms.push_back(o);
      end
      ndig = 0;
      do begin
         digits[ndig] = int'(mag % pred_base);
         ndig++;
         mag = mag / pred_base;
      end while (mag != 0);
      for (int i = ndig - 1; i >= 0; i--) begin
         o = '{pred_alphabet[digits[i]], 1'b0, i == 0};
         expected_syms.push_back(o);
      end
   endfunction

   // Driver: present the oldest pending request, idling at random.
   always @(negedge clock) begin
      if (reset) begin
         start <= 1'b0;
      end else if (!start || req_taken) begin
         if (pending_reqs.size() > 0 && !hold_sender &&
             ((accepted >= 120 && accepted < 200) || $urandom_range(99) >= 19)) begin
            req_opcode       <= pending_reqs[0].op;
            req_symbol_index <= pending_reqs[0].idx;
            req_symbol_value <= pending_reqs[0].val;
            req_number       <= pending_reqs[0].num;
            start            <= 1'b1;
         end else begin
            start <= 1'b0;
         end
      end
      req_taken = 0;
   end

   // Monitor: predict on acceptance, check every result strobe, watch for hangs.
   always @(posedge clock) begin
      symbol_out_type want;
      request_type    r;
      if (!reset) begin
         stall_cycles++;
         if (start && !busy) begin
            r = '{req_opcode, req_symbol_index, req_symbol_value, req_number};
            predict_symbols(r);
            void'(pending_reqs.pop_front());
            req_taken = 1;
            accepted++;
            stall_cycles = 0;
         end
         if (rsp_valid) begin
            stall_cycles = 0;
            if (expected_syms.size() == 0) begin
               report_mismatch("unexpected result", rsp_symbol, 0);
            end else begin
               want = expected_syms.pop_front();
               if (rsp_symbol !== want.sym) report_mismatch("symbol", rsp_symbol, want.sym);
               if (rsp_error !== want.err) report_mismatch("error", rsp_error, want.err);
               if (rsp_last !== want.last) report_mismatch("last", rsp_last, want.last);
            end
         end
         if (stall_cycles >= StallLimit) begin
            $display("Regression FAIL");
            $finish;
         end
      end
   end

   task automatic queue_write(input int idx, input int val);
      request_type r;
      r = '{OpWrite, idx[IdxWidth-1:0], val[7:0], '0};
      pending_reqs.push_back(r);
   endtask

   task automatic queue_convert(input logic signed [ValueWidth-1:0] n);
      request_type r;
      r = '{OpConvert, IdxWidth'($urandom), 8'($urandom), n};
      pending_reqs.push_back(r);
   endtask

   // Drain everything, let the block settle, then write the base length.
   task automatic set_base(input int len);
      wait (pending_reqs.size() == 0 && expected_syms.size() == 0);
      repeat (40) @(posedge clock);
      wait (!busy);
      @(negedge clock);
      csr_we    <= 1'b1;
      csr_wdata <= len[7:0];
      pred_base = len[7:0];
      @(negedge clock);
      csr_we <= 1'b0;
   endtask

   // Load shuffled legal symbols into entries 0..len-1 (random bytes past the 92 legal ones).
   task automatic load_alphabet(input int len);
      logic [7:0] pool[$];
      logic [7:0] t;
      int j;
      pool = printable;
      for (int i = pool.size() - 1; i > 0; i--) begin
         j = $urandom_range(i);
         t = pool[i]; pool[i] = pool[j]; pool[j] = t;
      end
      for (int i = 0; i < len && i < MaxSymbols; i++)
         queue_write(i, i < pool.size() ? pool[i] : $urandom_range(255));
   endtask

   function automatic logic signed [ValueWidth-1:0] random_number();
      case ($urandom_range(5))
         0: return $urandom_range(20);
         1: return -$signed(ValueWidth'($urandom_range(20)));
         2: return {1'b1, {(ValueWidth-1){1'b0}}};
         3: return {1'b0, {(ValueWidth-1){1'b1}}};
         default: return $urandom;
      endcase
   endfunction

   initial begin
      int len, n;
      for (int c = SymSpace + 1; c < SymDel; c++)
         if (c != SymMinus && c != SymPlus) printable.push_back(c[7:0]);
      pred_base = '0;
      for (int i = 0; i < MaxSymbols; i++) pred_alphabet[i] = '0;
      repeat (3) @(posedge clock);
      @(negedge clock);
      reset = 1'b0;

      // Directed: write a decimal alphabet before anything reads it.
      for (int i = 0; i < 10; i++)
         queue_write(i, "0" + i);
      queue_convert(5);                       // base length zero
      set_base(1);
      queue_convert(0);                       // base length one
      set_base(10);
      queue_convert(0);                       // zero emits alphabet[0]
      queue_convert(-1);
      queue_convert(32'sh7FFF_FFFF);
      queue_convert(32'sh8000_0000);          // most negative value
      queue_write(1, SymPlus);                // illegal symbol
      queue_convert(7);
      queue_write(1, "0");                    // duplicate symbol
      queue_convert(7);
      queue_write(1, 8'd0);
      queue_convert(7);
      queue_write(1, "1");
      queue_convert(12345);
      set_base(255);                          // oversized length
      queue_convert(3);
      set_base(2);
      queue_convert(32'sh8000_0000);          // longest output: sign and 32 digits

      // Random phases: one full-size table, one oversized length, one too
      // short, the rest short alphabets.
      for (int ph = 0; ph < 9; ph++) begin
         case (ph)
            0: len = MaxSymbols;
            1: len = 255;
            2: len = $urandom_range(1) ? 0 : 1;
            default: len = $urandom_range(2, 20);
         endcase
         set_base(len);
         if (len <= MaxSymbols) load_alphabet(len);
         n = (len > 40) ? 3 : 14;
         for (int k = 0; k < n; k++) begin
            if ($urandom_range(9) == 0) begin
               // corrupt or restore one entry in use, or touch one beyond it
               queue_write($urandom_range(MaxSymbols - 1),
                           $urandom_range(1) ? $urandom_range(255)
                                             : printable[$urandom_range(91)]);
            end
            queue_convert(random_number());
         end
         if (ph == 4) begin
            // wait until every expected result is back, then hold the sender
            wait (pending_reqs.size() == 0 && expected_syms.size() == 0);
            hold_sender = 1;
            repeat (30) @(posedge clock);
            hold_sender = 0;
         end
      end

      wait (pending_reqs.size() == 0 && expected_syms.size() == 0);
      repeat (100) @(posedge clock);
      if (mismatches == 0 && expected_syms.size() == 0) begin
         $display("Regression PASS");
      end else begin
         $display("Regression FAIL");
      end
      $finish;
   end
endmodule
